// ----- src/bist_pkg.sv -----
// Shared types and codes for the bounded integer set table.
package bist_pkg;

  // Request codes; the spare code behaves as a query
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // Register map (word index) and reset values
  localparam logic       REG_CAPACITY = 1'b0;
  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic       accepted;
    logic [4:0] count;
  } out_item_t;

endpackage

// ----- src/bounded_integer_set_table.sv -----
// Top level of the bounded integer set table: sequencer, valid bits, count and result register.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o  bist_pkg::in_item_t  (kind, value)
//   out      out  out_valid_o/out_stall_i bist_pkg::out_item_t (found, accepted, count)
//   cfg      in   APB psel/penable/pready capacity at byte address 0
//
// Each item passes through an idle state that takes it, a scan state that reads one slot
// a cycle through the single read port of the value RAM, a drain state for the last compare,
// and an update state. Reset clears the valid bits, the count and the sequencer at once;
// capacity returns to 16. A stalled result holds in the output register; a new item is
// taken meanwhile, and its update waits until that result goes.
module bounded_integer_set_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bist_pkg::in_item_t  in_item_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bist_pkg::out_item_t out_item_o,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
  localparam logic [LW-1:0] MAX_CNT  = LW'(MAX_ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]          cmp_idx_q;
  logic                   hit_q, hit_d;
  logic [IW-1:0]          hit_idx_q, hit_idx_d;
  logic                   free_q, free_d;
  logic [IW-1:0]          free_idx_q, free_idx_d;
  logic [1:0]             kind_q;
  logic [31:0]            value_q;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]          count_q, count_d;
  logic [4:0]             cap_q;
  logic                   out_valid_q;
  bist_pkg::out_item_t    out_item_q;
  logic [31:0]            rdata;
  logic                   in_acc, commit, ins_ok, rem_ok;
  logic [LW-1:0]          cap_ext, limit, count_ext;
  logic                   cfg_wr;

  // Value store, scanned one slot a cycle
  bist_ram #(
    .WIDTH(32),
    .DEPTH(MAX_ENTRIES)
  ) u_values (
    .clk_i  (clk_i),
    .we_i   (commit && ins_ok),
    .waddr_i(free_idx_q),
    .wdata_i(value_q),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  // Configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == bist_pkg::REG_CAPACITY) ? {27'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bist_pkg::CAPACITY_RESET;
    end else if (cfg_wr && (paddr[2] == bist_pkg::REG_CAPACITY)) begin
      cap_q <= pwdata[4:0];
    end
  end

  // Handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign commit      = (state_q == S_UPDATE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Decide the update from the scan outcome
  assign cap_ext   = LW'(cap_q);
  assign limit     = (cap_ext < MAX_CNT) ? cap_ext : MAX_CNT;
  assign count_ext = LW'(count_q);
  assign ins_ok    = (kind_q == bist_pkg::KIND_INSERT) && (count_ext < limit) && free_q;
  assign rem_ok    = (kind_q == bist_pkg::KIND_REMOVE) && hit_q;

  // Sequencer and scan bookkeeping
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmp_vld_d  = 1'b0;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    valid_d    = valid_q;
    count_d    = count_q;

    // Record the lowest matching slot, one compare a cycle
    if (cmp_vld_q && !hit_q && valid_q[cmp_idx_q] && (rdata == value_q)) begin
      hit_d     = 1'b1;
      hit_idx_d = cmp_idx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SCAN;
          idx_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      S_SCAN: begin
        cmp_vld_d = 1'b1;
        // Record the lowest free slot
        if (!free_q && !valid_q[idx_q]) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
        end
        if (idx_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (commit) begin
          state_d = S_IDLE;
          if (ins_ok) begin
            valid_d[free_idx_q] = 1'b1;
            count_d             = count_q + 1'b1;
          end else if (rem_ok) begin
            valid_d[hit_idx_q] = 1'b0;
            count_d            = count_q - 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      valid_q   <= '0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
    end
  end

  // Scan payload
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cmp_idx_q  <= idx_q;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (in_acc) begin
      kind_q  <= in_item_i.kind;
      value_q <= $unsigned(in_item_i.value);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_item_q.found    <= hit_q;
      out_item_q.accepted <= ins_ok || rem_ok;
      out_item_q.count    <= 5'(count_d);
    end
  end

  // Count tracks the valid bits exactly
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(count_q))
    else $error("count differs from number of valid slots");

  // Count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(count_q) <= MAX_CNT)
    else $error("count above table depth");

  // A query leaves the table untouched
  a_query_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (kind_q != bist_pkg::KIND_INSERT) && (kind_q != bist_pkg::KIND_REMOVE))
    |=> $stable(valid_q) && $stable(count_q))
    else $error("query changed the table");

  // A committed update always presents a result
  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("update without result");

  // An insert is taken only below the effective capacity
  a_insert_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && ins_ok) |-> (count_ext < limit) && !valid_q[free_idx_q])
    else $error("insert beyond capacity or into a used slot");

endmodule

// ----- src/bist_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- verif/bounded_integer_set_table_test.sv -----
// Self-checking testbench for the bounded integer set table: directed rows, then random phases.
`timescale 1ns / 1ps

module bounded_integer_set_table_test;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES = 29;
  localparam int PHASE_ITEMS = 50;
  // The spare request code has no name in the package; it behaves as a query
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  // One directed row: either a capacity write or an item, with a typed result where obvious
  typedef struct {
    bit          cfg;
    logic [4:0]  cap;
    logic [1:0]  kind;
    logic [31:0] value;
    bit          typed;
    bit          found;
    bit          accepted;
    logic [4:0]  count;
  } step_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  bist_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  bist_pkg::out_item_t out_item_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Mirror of the set held by the block
  logic [31:0] table_vals [TABLE_DEPTH];
  bit          table_live [TABLE_DEPTH];
  int          table_count;
  logic [4:0]  cap_reg;

  bist_pkg::out_item_t awaited_results [$];
  bist_pkg::out_item_t oldest_result;
  int                  fail_count = 0;
  int                  cycle_count = 0;
  int                  burst_left = 0;
  stall_mode_e         stall_mode = STALL_NONE;
  int                  stall_left = 0;
  logic [31:0]         value_pool [8];

  step_row_t plan [25] = '{
    '{0, 0, bist_pkg::KIND_QUERY,  32'h0000_0000, 1, 0, 0, 0},
    '{0, 0, bist_pkg::KIND_REMOVE, 32'h0000_0005, 1, 0, 0, 0},
    '{0, 0, bist_pkg::KIND_INSERT, 32'h7fff_ffff, 1, 0, 1, 1},
    '{0, 0, bist_pkg::KIND_INSERT, 32'h8000_0000, 1, 0, 1, 2},
    '{0, 0, bist_pkg::KIND_INSERT, 32'hffff_ffff, 1, 0, 1, 3},
    '{0, 0, bist_pkg::KIND_INSERT, 32'hffff_ffff, 1, 1, 1, 4},
    '{0, 0, bist_pkg::KIND_QUERY,  32'h8000_0000, 1, 1, 0, 4},
    '{0, 0, KIND_SPARE,            32'hffff_ffff, 1, 1, 0, 4},
    '{0, 0, bist_pkg::KIND_REMOVE, 32'hffff_ffff, 1, 1, 1, 3},
    '{0, 0, bist_pkg::KIND_QUERY,  32'hffff_ffff, 1, 1, 0, 3},
    '{1, 3, bist_pkg::KIND_QUERY,  32'h0000_0000, 0, 0, 0, 0},
    '{0, 0, bist_pkg::KIND_INSERT, 32'h0000_0000, 1, 0, 0, 3},
    '{1, 0, bist_pkg::KIND_QUERY,  32'h0000_0000, 0, 0, 0, 0},
    '{0, 0, bist_pkg::KIND_REMOVE, 32'h7fff_ffff, 1, 1, 1, 2},
    '{0, 0, bist_pkg::KIND_INSERT, 32'h0000_0001, 1, 0, 0, 2},
    '{1, 31, bist_pkg::KIND_QUERY, 32'h0000_0000, 0, 0, 0, 0},
    '{0, 0, bist_pkg::KIND_INSERT, 32'h0000_0002, 1, 0, 1, 3},
    '{0, 0, bist_pkg::KIND_INSERT, 32'h0000_0002, 1, 1, 1, 4},
    '{0, 0, bist_pkg::KIND_REMOVE, 32'hffff_ffff, 1, 1, 1, 3},
    '{0, 0, bist_pkg::KIND_REMOVE, 32'h8000_0000, 1, 1, 1, 2},
    '{0, 0, bist_pkg::KIND_QUERY,  32'h0000_0002, 1, 1, 0, 2},
    '{0, 0, bist_pkg::KIND_REMOVE, 32'h0000_0002, 1, 1, 1, 1},
    '{0, 0, bist_pkg::KIND_REMOVE, 32'h0000_0002, 1, 1, 1, 0},
    '{0, 0, bist_pkg::KIND_REMOVE, 32'h0000_0002, 1, 0, 0, 0},
    '{1, 16, bist_pkg::KIND_QUERY, 32'h0000_0000, 0, 0, 0, 0}
  };

  bounded_integer_set_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Work out the result of one request and advance the mirrored set
  function automatic bist_pkg::out_item_t predict_set_response(input bist_pkg::in_item_t req);
    int hit;
    int free;
    int limit;
    bist_pkg::out_item_t rsp;
    hit = -1;
    free = -1;
    limit = (int'(cap_reg) < TABLE_DEPTH) ? int'(cap_reg) : TABLE_DEPTH;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (table_live[i] && table_vals[i] == req.value) hit = i;
      if (!table_live[i]) free = i;
    end
    rsp.found = (hit >= 0);
    rsp.accepted = 1'b0;
    case (req.kind)
      bist_pkg::KIND_INSERT: begin
        if (table_count < limit && free >= 0) begin
          table_vals[free] = req.value;
          table_live[free] = 1'b1;
          table_count++;
          rsp.accepted = 1'b1;
        end
      end
      bist_pkg::KIND_REMOVE: begin
        if (hit >= 0) begin
          table_live[hit] = 1'b0;
          if (table_count > 0) table_count--;
          rsp.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    rsp.count = table_count[4:0];
    return rsp;
  endfunction

  // Present one item, honoring the burst pattern, and log its result once accepted
  task automatic send_item(input bist_pkg::in_item_t req, input bit typed,
                           input bist_pkg::out_item_t typed_rsp);
    int gap;
    bist_pkg::out_item_t rsp;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_item_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    rsp = predict_set_response(req);
    awaited_results.push_back(typed ? typed_rsp : rsp);
  endtask

  // Drop valid and hold until every logged result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Write the capacity register: setup cycle, then access cycle
  task automatic write_capacity(input logic [4:0] cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {bist_pkg::REG_CAPACITY, 2'b00};
    pwdata <= 32'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_reg = cap;
  endtask

  // Receiver stall pattern: switch between free flow, light and heavy stalling
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 2) == 0);
      default:     out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Compare each result leaving the block with the oldest one logged
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("result with no item outstanding: %p", out_item_o);
        fail_count++;
      end else begin
        oldest_result = awaited_results.pop_front();
        if (out_item_o.found !== oldest_result.found) begin
          $error("found: expected %0d, got %0d", oldest_result.found, out_item_o.found);
          fail_count++;
        end
        if (out_item_o.accepted !== oldest_result.accepted) begin
          $error("accepted: expected %0d, got %0d", oldest_result.accepted,
                 out_item_o.accepted);
          fail_count++;
        end
        if (out_item_o.count !== oldest_result.count) begin
          $error("count: expected %0d, got %0d", oldest_result.count, out_item_o.count);
          fail_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    bist_pkg::in_item_t req;
    bist_pkg::out_item_t typed_rsp;
    logic [4:0] cap;
    int ins_pct;
    int rem_pct;
    int pick;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      table_vals[i] = '0;
      table_live[i] = 1'b0;
    end
    table_count = 0;
    cap_reg = bist_pkg::CAPACITY_RESET;

    // Hold reset, then release it once
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (plan[r]) begin
      if (plan[r].cfg) begin
        wait_drained();
        write_capacity(plan[r].cap);
      end else begin
        req.kind = plan[r].kind;
        req.value = plan[r].value;
        typed_rsp.found = plan[r].found;
        typed_rsp.accepted = plan[r].accepted;
        typed_rsp.count = plan[r].count;
        send_item(req, plan[r].typed, typed_rsp);
      end
    end

    // Random phases: new capacity, value pool and request mix each time
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: cap = 5'd16;
        1: cap = 5'd31;
        2: cap = 5'd0;
        3: cap = 5'd1;
        4: cap = 5'd8;
        5: cap = 5'd17;
        default: cap = 5'($urandom_range(0, 31));
      endcase
      write_capacity(cap);
      foreach (value_pool[k]) begin
        case ($urandom_range(0, 3))
          0: value_pool[k] = $urandom_range(0, 7);
          1: value_pool[k] = 32'hffff_fff8 | 32'($urandom_range(0, 7));
          2: value_pool[k] = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
          default: value_pool[k] = $urandom;
        endcase
      end
      ins_pct = $urandom_range(30, 85);
      rem_pct = $urandom_range(0, 100 - ins_pct);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // In phase 2 only, pause once mid-phase until the block has emptied
        if (p == 2 && n == PHASE_ITEMS / 2) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < ins_pct) req.kind = bist_pkg::KIND_INSERT;
        else if (pick < ins_pct + rem_pct) req.kind = bist_pkg::KIND_REMOVE;
        else if (pick < 95) req.kind = bist_pkg::KIND_QUERY;
        else req.kind = KIND_SPARE;
        req.value = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, 7)]
                                                 : 32'($urandom);
        typed_rsp = '0;
        send_item(req, 1'b0, typed_rsp);
      end
    end

    // Drain and let any stray result surface
    wait_drained();
    repeat (2 * (TABLE_DEPTH + 3)) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
